### sv/sorted_list_engine_top_defines.svh
// Assertion macros for the sorted list engine.
// Used by sorted_list_engine_top; no other dependencies.
`ifndef SORTED_LIST_ENGINE_TOP_DEFINES_SVH
`define SORTED_LIST_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SLE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted list engine check failed");
`define SLE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sorted list engine check failed");
`else
`define SLE_ASSERT(lbl, prop)
`define SLE_ASSERT_RST(lbl, prop)
`endif

`endif

### sv/sle_pkg.sv
// Shared types, codes and sizes for the sorted list engine.
// No dependencies; used by sle_cell and sorted_list_engine_top.
package sle_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;
    localparam int VAL_W    = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    valid;
        logic                    gt;
        logic                    hit;
    } link_t;

endpackage

### sv/sorted_list_engine_top.sv
// Sorted list engine: a row of CAPACITY cells kept in ascending order.
// A response is registered and presented in the cycle after its request beat.
// One request per cycle while the response side takes each response; the compare and shift
// ripple combinationally through the cell row, so the chain of match and shift links sets the clock period.
// Reset clears occupancy and every valid bit; stored values are not reset.
// Depends on sle_pkg, sle_cell and sorted_list_engine_top_defines.svh.
`include "sorted_list_engine_top_defines.svh"

module sorted_list_engine_top
    import sle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam link_t HEAD_LINK = '{val: '0, valid: 1'b1, gt: 1'b0, hit: 1'b0};
    localparam link_t TAIL_LINK = '{val: '0, valid: 1'b0, gt: 1'b1, hit: 1'b0};

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             fire;
    logic             full;
    logic             found;
    logic [1:0]       status;
    cell_ctrl_t       ctrl;
    link_t            links [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found     = links[CAPACITY-1].hit;

    assign ctrl.insert = fire && (req.op == OP_INSERT) && !full;
    assign ctrl.remove = fire && (req.op == OP_REMOVE);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            link_t left_l;
            link_t right_l;
            if (gi == 0)
            begin : g_head
                assign left_l = HEAD_LINK;
            end
            else
            begin : g_mid_l
                assign left_l = links[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_l = TAIL_LINK;
            end
            else
            begin : g_mid_r
                assign right_l = links[gi+1];
            end
            sle_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .value (req.value),
                .left  (left_l),
                .right (right_l),
                .link  (links[gi])
            );
            assign valid_vec[gi] = links[gi].valid;
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        status     = ST_MISS;
        case (req.op)
            OP_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_OK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    status     = ST_OK;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_SEARCH:
            begin
                if (found)
                begin
                    status = ST_OK;
                end
            end
            default:
            begin
                status = ST_MISS;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (fire)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.status    = status;
            rsp_next.occupancy = OCC_W'(count_next);
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SLE_ASSERT_RST(a_count_bound, !rst_n || count_reg <= CNT_W'(CAPACITY))
    `SLE_ASSERT(a_valid_count, $countones(valid_vec) == int'(count_reg))
    `SLE_ASSERT(a_valid_packed, $onehot0(valid_vec & ~(valid_vec >> 1)))
    `SLE_ASSERT(a_head_valid, valid_vec[0] == (count_reg != '0))
    `SLE_ASSERT(a_full_holds, fire && req.op == OP_INSERT && full |=> count_reg == $past(count_reg))
    `SLE_ASSERT(a_rsp_occupancy, fire |=> rsp.occupancy == OCC_W'(count_reg))

endmodule

### sv/sle_cell.sv
// One slot of the sorted row: holds a value and its valid bit.
// Depends on sle_pkg; instantiated in a chain by sorted_list_engine_top.
module sle_cell
    import sle_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic signed [VAL_W-1:0] value,
    input  link_t                   left,
    input  link_t                   right,
    output link_t                   link
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    gt;
    logic                    hit;

    assign gt  = !valid_reg || (value < val_reg);
    assign hit = left.hit || (valid_reg && (val_reg == value));

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (gt)
            begin
                val_next   = left.gt ? left.val : value;
                valid_next = valid_reg | left.valid;
            end
        end
        else if (ctrl.remove && hit)
        begin
            // pull the right neighbor in over the removed entry
            val_next   = right.val;
            valid_next = right.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.val   = val_reg;
    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.hit   = hit;

endmodule

### sim/sorted_list_engine_top_tb.sv
// Testbench for sorted_list_engine_top: directed and random insert, remove and search
// requests, each response beat checked against a sorted list kept in the bench.
// Depends on sle_pkg and the sorted_list_engine_top RTL.
module sorted_list_engine_top_tb;
    import sle_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam int IDLE_PCT        = 18;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int DRAIN_CYCLES    = 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic signed [VAL_W-1:0] held_values[$];
    rsp_t expected_rsps[$];
    int   error_count  = 0;
    logic idle_enable  = 1'b1;
    int   rsp_hold_seq = 0;

    sorted_list_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic rsp_t apply_request(input req_t beat);
        rsp_t result;
        int   pos;
        result.status = ST_MISS;
        pos = 0;
        case (beat.op)
            OP_INSERT:
            begin
                if (held_values.size() >= CAPACITY)
                    result.status = ST_FULL;
                else
                begin
                    // place after every entry not greater than the new value
                    while (pos < held_values.size() && !(beat.value < held_values[pos]))
                        pos++;
                    held_values.insert(pos, beat.value);
                    result.status = ST_OK;
                end
            end
            OP_REMOVE:
            begin
                while (pos < held_values.size() && held_values[pos] != beat.value)
                    pos++;
                if (pos < held_values.size())
                begin
                    held_values.delete(pos);
                    result.status = ST_OK;
                end
            end
            OP_SEARCH:
            begin
                while (pos < held_values.size() && held_values[pos] != beat.value)
                    pos++;
                if (pos < held_values.size())
                    result.status = ST_OK;
            end
            default: ;
        endcase
        result.occupancy = OCC_W'(held_values.size());
        return result;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45 && held_values.size() != 0)
            return held_values[$urandom_range(held_values.size() - 1)];
        if (roll < 75)
            return VAL_W'(int'($urandom_range(8)) - 4);
        if (roll < 87)
        begin
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic signed [VAL_W-1:0] value);
        req_t beat;
        beat.op    = op;
        beat.value = value;
        while (idle_enable && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsps.push_back(apply_request(beat));
    endtask

    task automatic send_random_request(input bit fill_bias);
        int         roll;
        logic [1:0] op;
        roll = $urandom_range(99);
        if (roll < 3)
            op = OP_UNUSED;
        else if (roll < 20)
            op = OP_SEARCH;
        else if (roll < (fill_bias ? 80 : 35))
            op = OP_INSERT;
        else
            op = OP_REMOVE;
        send_request(op, pick_value());
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_list();
        send_request(OP_SEARCH, '0);
        send_request(OP_REMOVE, VAL_MIN);
        send_request(OP_UNUSED, VAL_MAX);
    endtask

    task automatic test_fill_to_capacity();
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_INSERT, VAL_MIN);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, 5);
        send_request(OP_INSERT, 5);
        while (held_values.size() < CAPACITY)
            send_request(OP_INSERT, VAL_W'(int'($urandom_range(8)) - 4));
        send_request(OP_INSERT, 7);
        send_request(OP_SEARCH, 1000);
        send_request(OP_SEARCH, VAL_MAX);
        send_request(OP_REMOVE, 1000);
        send_request(OP_UNUSED, 5);
        send_request(OP_REMOVE, VAL_MIN);
        send_request(OP_REMOVE, 5);
    endtask

    task automatic test_random_traffic(input int bursts);
        for (int b = 0; b < bursts; b++)
        begin
            idle_enable <= (b != 3);
            for (int i = 0; i < 100; i++)
                send_random_request(b[0] == 1'b0);
        end
        idle_enable <= 1'b1;
    endtask

    task automatic test_output_stall();
        rsp_hold_seq <= rsp_hold_seq + 1;
        for (int i = 0; i < 100; i++)
            send_random_request(i < 50);
    endtask

    task automatic test_sender_pause();
        for (int p = 0; p < 5; p++)
        begin
            for (int i = 0; i < 40; i++)
                send_random_request(p[0] == 1'b0);
            wait_for_responses();
        end
    endtask

    initial
    begin
        int   hold_seen = 0;
        int   hold_left = 0;
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.occupancy !== want.occupancy)
                    begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               want.occupancy, rsp.occupancy);
                        error_count++;
                    end
                end
            end
            // hold off the response side for a long stretch on request
            if (rsp_hold_seq != hold_seen)
            begin
                hold_seen = rsp_hold_seq;
                hold_left = RSP_HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        int cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_list_engine_top_tb failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_fill_to_capacity();
        test_random_traffic(15);
        test_output_stall();
        test_sender_pause();
        wait_for_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("sorted_list_engine_top_tb passed");
        else
            $display("sorted_list_engine_top_tb failed");
        $finish;
    end

endmodule
